FILE: hdl/adll_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the array-based doubly linked list.
// Used by hdl/array_doubly_linked_list.sv and dv/tb_array_doubly_linked_list.sv; no dependencies.

package adll_pkg;

	localparam int POOL_NODES_DEF = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths of the request and result beats
	localparam int REQ_W  = 3;
	localparam int NODE_W = 11;
	localparam int ITEM_W = 32;
	localparam int STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_INS_HEAD  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_TAIL  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INS_LEFT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INS_RIGHT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_WALK      = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic [NODE_W-1:0]        node_number;
		logic signed [ITEM_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [NODE_W-1:0]        result_node;
		logic signed [ITEM_W-1:0] result_value;
		logic                     at_end;
	} rsp_t;

endpackage

FILE: hdl/adll_links.sv
`timescale 1ns / 1ps
// Next and prev link memories of the list, with the two sentinel links in flops.
// Depends on nothing outside this file.

module adll_links #(
	parameter int POOL_NODES = 1024,
	localparam int SLOT_W = $clog2(POOL_NODES + 2)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] rd_slot,
	output logic [SLOT_W-1:0] next_rd,
	output logic [SLOT_W-1:0] prev_rd,
	input  logic              nx_we,
	input  logic [SLOT_W-1:0] nx_slot,
	input  logic [SLOT_W-1:0] nx_data,
	input  logic              pv_we,
	input  logic [SLOT_W-1:0] pv_slot,
	input  logic [SLOT_W-1:0] pv_data
);

	localparam int SLOTS = POOL_NODES + 2;
	localparam logic [SLOT_W-1:0] HEAD_SLOT = '0;
	localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);

	logic [SLOT_W-1:0] next_mem [SLOTS];
	logic [SLOT_W-1:0] prev_mem [SLOTS];
	logic [SLOT_W-1:0] next_mem_q;
	logic [SLOT_W-1:0] prev_mem_q;
	logic              rd_head_q;
	logic              rd_tail_q;
	logic [SLOT_W-1:0] head_next_q;
	logic [SLOT_W-1:0] tail_prev_q;

	always_ff @(posedge clk) begin
		if (nx_we && nx_slot != HEAD_SLOT) begin
			next_mem[nx_slot] <= nx_data;
		end
		if (pv_we && pv_slot != TAIL_SLOT) begin
			prev_mem[pv_slot] <= pv_data;
		end
		next_mem_q <= next_mem[rd_slot];
		prev_mem_q <= prev_mem[rd_slot];
		rd_head_q  <= (rd_slot == HEAD_SLOT);
		rd_tail_q  <= (rd_slot == TAIL_SLOT);
	end

	// sentinel links: empty list has head -> tail and tail -> head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_next_q <= TAIL_SLOT;
			tail_prev_q <= HEAD_SLOT;
		end else begin
			if (nx_we && nx_slot == HEAD_SLOT) begin
				head_next_q <= nx_data;
			end
			if (pv_we && pv_slot == TAIL_SLOT) begin
				tail_prev_q <= pv_data;
			end
		end
	end

	assign next_rd = rd_head_q ? head_next_q : next_mem_q;
	assign prev_rd = rd_tail_q ? tail_prev_q : prev_mem_q;

endmodule

FILE: hdl/array_doubly_linked_list.sv
`timescale 1ns / 1ps
// Top level of the array-based doubly linked list: request sequencer and node store.
// Depends on adll_pkg and adll_links.

// A request beat is taken on a clock edge with start high and busy low. Each request
// gives exactly one result beat, shown for one cycle with done high; the receiver
// cannot stall it, so capture it on that edge. Nodes take pool slots in insertion
// order, node k in slot k+1 (slot 0 is the head, slot 1 the tail); slots are never
// reused, so after POOL_NODES inserts every head or tail insert, and every left or
// right insert at a live node k, answers "pool full". An insert passes S_EVAL and
// S_LINK, a walk S_EVAL and S_VAL (only S_EVAL when it lands on the tail), a delete
// or any refused request only S_EVAL. The steps follow the dependent accesses to the
// link memories: one registered read of the target's links, then the writes (new
// node's own links, then the neighbors' links), or a second registered read of the
// successor's value for a walk. No clearing pass is needed after reset: the sentinel
// links sit in flops and every other entry is only read after it has been written.

module array_doubly_linked_list #(
	parameter int POOL_NODES = adll_pkg::POOL_NODES_DEF,
	parameter int VALUE_BITS = adll_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  adll_pkg::req_t req,
	output logic           done,
	output adll_pkg::rsp_t rsp
);

	localparam int SLOT_W = $clog2(POOL_NODES + 2);
	localparam int IDX_W  = $clog2(POOL_NODES);
	localparam int FREE_W = $clog2(POOL_NODES + 3);
	localparam int CMP_W  = (FREE_W > adll_pkg::NODE_W) ? FREE_W : adll_pkg::NODE_W;
	localparam int NODE_MEM_W = VALUE_BITS + 1;

	localparam logic [SLOT_W-1:0] HEAD_SLOT = '0;
	localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_TWO  = SLOT_W'(2);
	localparam logic [FREE_W-1:0] FREE_FIRST = FREE_W'(2);
	localparam logic [FREE_W-1:0] FREE_END   = FREE_W'(POOL_NODES + 2);
	localparam logic [FREE_W-1:0] FREE_ONE   = FREE_W'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_LINK,
		S_VAL
	} state_t;

	state_t             state_q;
	adll_pkg::req_t     req_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  after_q;
	logic [SLOT_W-1:0]  nx_q;
	logic [FREE_W-1:0]  free_q;
	logic               done_q;
	adll_pkg::rsp_t     rsp_q;

	// link memory ports
	logic [SLOT_W-1:0]  rd_slot;
	logic [SLOT_W-1:0]  next_rd;
	logic [SLOT_W-1:0]  prev_rd;
	logic               nx_we;
	logic [SLOT_W-1:0]  nx_slot;
	logic [SLOT_W-1:0]  nx_data;
	logic               pv_we;
	logic [SLOT_W-1:0]  pv_slot;
	logic [SLOT_W-1:0]  pv_data;

	// node store: alive flag over the value, one entry per node slot (no sentinels)
	logic [NODE_MEM_W-1:0] node_mem [POOL_NODES];
	logic [NODE_MEM_W-1:0] node_rd_q;
	logic [IDX_W-1:0]      nd_rd_idx;
	logic                  nd_we;
	logic [IDX_W-1:0]      nd_idx;
	logic [NODE_MEM_W-1:0] nd_data;

	// decisions taken in S_EVAL
	logic                        full;
	logic                        k_valid;
	logic [SLOT_W-1:0]           ev_after;
	logic [SLOT_W-1:0]           ev_nx;
	logic [adll_pkg::STAT_W-1:0] ev_stat;
	logic                        ev_ins;
	logic                        ev_del;
	logic                        ev_walk;
	logic [SLOT_W-1:0]           new_slot;
	logic [IDX_W-1:0]            new_idx;
	logic [VALUE_BITS-1:0]       wr_value;
	logic signed [VALUE_BITS-1:0] node_val;

	adll_links #(
		.POOL_NODES(POOL_NODES)
	) u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_slot (rd_slot),
		.next_rd (next_rd),
		.prev_rd (prev_rd),
		.nx_we   (nx_we),
		.nx_slot (nx_slot),
		.nx_data (nx_data),
		.pv_we   (pv_we),
		.pv_slot (pv_slot),
		.pv_data (pv_data)
	);

	assign full     = (free_q == FREE_END);
	assign new_slot = SLOT_W'(free_q);
	assign new_idx  = IDX_W'(free_q - FREE_FIRST);
	// keep the low VALUE_BITS of the beat, zero-filled when the store is wider
	assign wr_value = VALUE_BITS'({{adll_pkg::ITEM_W{1'b0}}, req_q.item_value});
	assign node_val = node_rd_q[VALUE_BITS-1:0];

	// k names a node only when 1 <= k <= nodes inserted so far and it is still alive
	assign k_valid = (req_q.node_number != '0)
		&& (CMP_W'(req_q.node_number) <= CMP_W'(free_q - FREE_FIRST))
		&& node_rd_q[VALUE_BITS];

	// Read the target's links on the accept edge: head for insert-at-head and for a
	// walk from the head, tail for insert-at-tail, else node k's slot.
	always_comb begin
		case (req.req_type)
			adll_pkg::REQ_INS_HEAD: rd_slot = HEAD_SLOT;
			adll_pkg::REQ_INS_TAIL: rd_slot = TAIL_SLOT;
			adll_pkg::REQ_WALK: begin
				rd_slot = (req.node_number == '0) ? HEAD_SLOT
					: SLOT_W'(req.node_number) + SLOT_ONE;
			end
			default: rd_slot = SLOT_W'(req.node_number) + SLOT_ONE;
		endcase
	end

	// node store read: alive flag of node k on accept, successor's value during a walk
	assign nd_rd_idx = (state_q == S_EVAL) ? IDX_W'(next_rd - SLOT_TWO)
		: IDX_W'(req.node_number - adll_pkg::NODE_W'(1));

	// Pick the new node's neighbors (after, nx) and check the request.
	always_comb begin
		ev_after = HEAD_SLOT;
		ev_nx    = TAIL_SLOT;
		ev_stat  = adll_pkg::STAT_OK;
		ev_ins   = 1'b0;
		ev_del   = 1'b0;
		ev_walk  = 1'b0;
		case (req_q.req_type)
			adll_pkg::REQ_INS_HEAD: begin
				ev_nx = next_rd;
				if (full) ev_stat = adll_pkg::STAT_FULL;
				else      ev_ins  = 1'b1;
			end
			adll_pkg::REQ_INS_TAIL: begin
				ev_after = prev_rd;
				if (full) ev_stat = adll_pkg::STAT_FULL;
				else      ev_ins  = 1'b1;
			end
			adll_pkg::REQ_DELETE: begin
				ev_after = prev_rd;
				ev_nx    = next_rd;
				if (!k_valid) ev_stat = adll_pkg::STAT_BAD;
				else          ev_del  = 1'b1;
			end
			adll_pkg::REQ_INS_LEFT: begin
				ev_after = prev_rd;
				ev_nx    = slot_q;
				if (!k_valid)  ev_stat = adll_pkg::STAT_BAD;
				else if (full) ev_stat = adll_pkg::STAT_FULL;
				else           ev_ins  = 1'b1;
			end
			adll_pkg::REQ_INS_RIGHT: begin
				ev_after = slot_q;
				ev_nx    = next_rd;
				if (!k_valid)  ev_stat = adll_pkg::STAT_BAD;
				else if (full) ev_stat = adll_pkg::STAT_FULL;
				else           ev_ins  = 1'b1;
			end
			adll_pkg::REQ_WALK: begin
				ev_nx = next_rd;
				if (req_q.node_number != '0 && !k_valid) ev_stat = adll_pkg::STAT_BAD;
				else                                     ev_walk = 1'b1;
			end
			default: ev_stat = adll_pkg::STAT_BAD;
		endcase
	end

	// Memory writes. Insert: new node's own links in S_EVAL, neighbors in S_LINK.
	// Delete: splice the neighbors together and drop the alive flag in S_EVAL.
	always_comb begin
		nx_we   = 1'b0;
		nx_slot = new_slot;
		nx_data = ev_nx;
		pv_we   = 1'b0;
		pv_slot = new_slot;
		pv_data = ev_after;
		nd_we   = 1'b0;
		nd_idx  = new_idx;
		nd_data = {1'b1, wr_value};
		if (state_q == S_EVAL && ev_ins) begin
			nx_we = 1'b1;
			pv_we = 1'b1;
			nd_we = 1'b1;
		end else if (state_q == S_EVAL && ev_del) begin
			nx_we   = 1'b1;
			nx_slot = ev_after;
			pv_we   = 1'b1;
			pv_slot = ev_nx;
			nd_we   = 1'b1;
			nd_idx  = IDX_W'(slot_q - SLOT_TWO);
			nd_data = '0;
		end else if (state_q == S_LINK) begin
			nx_we   = 1'b1;
			nx_slot = after_q;
			nx_data = new_slot;
			pv_we   = 1'b1;
			pv_slot = nx_q;
			pv_data = new_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (nd_we) begin
			node_mem[nd_idx] <= nd_data;
		end
		node_rd_q <= node_mem[nd_rd_idx];
	end

	// Sequencer with registered result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
			slot_q  <= '0;
			after_q <= '0;
			nx_q    <= '0;
			free_q  <= FREE_FIRST;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req;
						slot_q  <= SLOT_W'(req.node_number) + SLOT_ONE;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					after_q <= ev_after;
					nx_q    <= ev_nx;
					if (ev_ins) begin
						state_q <= S_LINK;
					end else if (ev_walk && ev_nx != TAIL_SLOT) begin
						// hold for the successor's value
						state_q <= S_VAL;
					end else begin
						done_q             <= 1'b1;
						rsp_q.status       <= ev_stat;
						rsp_q.result_node  <= '0;
						rsp_q.result_value <= '0;
						rsp_q.at_end       <= ev_walk;
						state_q            <= S_IDLE;
					end
				end
				S_LINK: begin
					// advance the free slot; node number is slot - 1
					free_q             <= free_q + FREE_ONE;
					done_q             <= 1'b1;
					rsp_q.status       <= adll_pkg::STAT_OK;
					rsp_q.result_node  <= adll_pkg::NODE_W'(free_q - FREE_ONE);
					rsp_q.result_value <= '0;
					rsp_q.at_end       <= 1'b0;
					state_q            <= S_IDLE;
				end
				S_VAL: begin
					done_q             <= 1'b1;
					rsp_q.status       <= adll_pkg::STAT_OK;
					rsp_q.result_node  <= adll_pkg::NODE_W'(nx_q - SLOT_ONE);
					rsp_q.result_value <= adll_pkg::ITEM_W'(node_val);
					rsp_q.at_end       <= 1'b0;
					state_q            <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// an accepted request always holds the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// one result beat per request: never two in a row, never while busy
	assert property (@(posedge clk) disable iff (!arst_n) done |-> (!busy && !$past(done)))
		else $error("result beat repeated or overlapped a busy cycle");

	// free slot pointer stays inside the pool and only moves on an insert
	assert property (@(posedge clk) disable iff (!arst_n)
		(free_q >= FREE_FIRST) && (free_q <= FREE_END))
		else $error("free slot pointer out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(free_q != $past(free_q)) |-> (done && rsp.status == adll_pkg::STAT_OK
			&& rsp.result_node != '0))
		else $error("free slot pointer moved without a completed insert");

endmodule

FILE: dv/tb_array_doubly_linked_list.sv
`timescale 1ns / 1ps
// Self-checking testbench for array_doubly_linked_list: directed and random list requests,
// each result beat compared with a behavioral copy of the linked list.
// Depends on hdl/adll_pkg.sv and hdl/array_doubly_linked_list.sv.

module tb_array_doubly_linked_list;

	localparam int POOL  = adll_pkg::POOL_NODES_DEF;
	localparam int SLOTS = POOL + 2;
	localparam int HEAD  = 0;
	localparam int TAIL  = 1;

	// request codes the block does not define; both must be refused
	localparam logic [adll_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [adll_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	localparam int RANDOM_ITEMS = 1330;
	localparam int DRAIN_CYCLES = 16;
	// slowest run: ~1350 beats, plus long sender gaps at 71% idle
	localparam int CYCLE_LIMIT  = 200000;

	// Behavioral copy of the list plus the queue of result beats still owed by the block.
	class list_tracker;
		logic signed [adll_pkg::ITEM_W-1:0] values [POOL];
		bit                                 alive [POOL];
		int                                 nxt [SLOTS];
		int                                 prv [SLOTS];
		int                                 free_slot;
		adll_pkg::rsp_t                     owed_rsp [$];
		int                                 errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				nxt[i] = 0;
				prv[i] = 0;
			end
			for (int i = 0; i < POOL; i++) begin
				values[i] = '0;
				alive[i]  = 1'b0;
			end
			nxt[HEAD] = TAIL;
			prv[TAIL] = HEAD;
			free_slot = 2;
			errors    = 0;
		endfunction

		function int node_count();
			return free_slot - 2;
		endfunction

		function bit node_live(int k);
			if (k < 1 || k > node_count())
				return 1'b0;
			return alive[k-1];
		endfunction

		// Link a fresh slot behind 'after'; return the new node number.
		function int link_after(int after, logic signed [adll_pkg::ITEM_W-1:0] v);
			int s;
			int nx;
			s  = free_slot;
			nx = nxt[after];
			values[s-2] = v;
			alive[s-2]  = 1'b1;
			prv[s]      = after;
			nxt[s]      = nx;
			prv[nx]     = s;
			nxt[after]  = s;
			free_slot   = s + 1;
			return s - 1;
		endfunction

		function adll_pkg::rsp_t predict_list_op(adll_pkg::req_t r);
			adll_pkg::rsp_t o;
			int             k;
			int             s;
			bit             full;
			o    = '0;
			k    = int'(r.node_number);
			full = free_slot >= SLOTS;
			case (r.req_type)
				adll_pkg::REQ_INS_HEAD, adll_pkg::REQ_INS_TAIL: begin
					if (full)
						o.status = adll_pkg::STAT_FULL;
					else
						o.result_node = adll_pkg::NODE_W'(link_after(
							(r.req_type == adll_pkg::REQ_INS_HEAD) ? HEAD : prv[TAIL],
							r.item_value));
				end
				adll_pkg::REQ_DELETE: begin
					if (!node_live(k)) begin
						o.status = adll_pkg::STAT_BAD;
					end else begin
						s = k + 1;
						nxt[prv[s]] = nxt[s];
						prv[nxt[s]] = prv[s];
						alive[k-1]  = 1'b0;
					end
				end
				adll_pkg::REQ_INS_LEFT, adll_pkg::REQ_INS_RIGHT: begin
					// a bad k wins over a full pool
					s = k + 1;
					if (!node_live(k))
						o.status = adll_pkg::STAT_BAD;
					else if (full)
						o.status = adll_pkg::STAT_FULL;
					else
						o.result_node = adll_pkg::NODE_W'(link_after(
							(r.req_type == adll_pkg::REQ_INS_LEFT) ? prv[s] : s,
							r.item_value));
				end
				adll_pkg::REQ_WALK: begin
					if (k != 0 && !node_live(k)) begin
						o.status = adll_pkg::STAT_BAD;
					end else begin
						s = (k == 0) ? HEAD : k + 1;
						if (nxt[s] == TAIL) begin
							o.at_end = 1'b1;
						end else begin
							o.result_node  = adll_pkg::NODE_W'(nxt[s] - 1);
							o.result_value = values[nxt[s] - 2];
						end
					end
				end
				default: o.status = adll_pkg::STAT_BAD;
			endcase
			return o;
		endfunction

		function adll_pkg::rsp_t note_request(adll_pkg::req_t r);
			adll_pkg::rsp_t e;
			e = predict_list_op(r);
			owed_rsp.push_back(e);
			return e;
		endfunction

		task flag_mismatch(string msg);
			errors++;
			// keep the log short on a badly broken build
			if (errors <= 100)
				$display("mismatch: %s", msg);
		endtask

		task check_result(adll_pkg::rsp_t got);
			adll_pkg::rsp_t e;
			if (owed_rsp.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing owed: %p", got));
				return;
			end
			e = owed_rsp.pop_front();
			if (got.status !== e.status)
				flag_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
			if (got.result_node !== e.result_node)
				flag_mismatch($sformatf("result_node %0d, want %0d",
					got.result_node, e.result_node));
			if (got.result_value !== e.result_value)
				flag_mismatch($sformatf("result_value %0d, want %0d",
					got.result_value, e.result_value));
			if (got.at_end !== e.at_end)
				flag_mismatch($sformatf("at_end %0b, want %0b", got.at_end, e.at_end));
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           done;
	adll_pkg::req_t req;
	adll_pkg::rsp_t rsp;

	list_tracker tracker;
	int          sender_idle_pct;
	int          walk_cursor;
	int          cycles;

	array_doubly_linked_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles; a hung block ends the run here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_array_doubly_linked_list NOT OK");
			$finish;
		end
	end

	// Result beats last one cycle and cannot be held off: capture every done cycle.
	// Values read right after the edge are the ones the edge sampled.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(rsp);
	end

	function automatic adll_pkg::req_t make_req(logic [adll_pkg::REQ_W-1:0] op, int k,
		logic signed [adll_pkg::ITEM_W-1:0] v);
		adll_pkg::req_t r;
		r.req_type    = op;
		r.node_number = adll_pkg::NODE_W'(k);
		r.item_value  = v;
		return r;
	endfunction

	// Mostly a node number that exists; now and then anything the field can hold.
	function automatic int pick_node_k();
		int count;
		count = tracker.node_count();
		if (count == 0 || $urandom_range(0, 99) < 10)
			return $urandom_range(0, (1 << adll_pkg::NODE_W) - 1);
		return $urandom_range(1, count);
	endfunction

	// Until the pool fills, lean hard on inserts so the full-pool cases get reached
	// within the run; after that, mostly walks and deletes against a full pool.
	function automatic adll_pkg::req_t make_random_req();
		adll_pkg::req_t r;
		int             roll;
		bit             full;
		full          = tracker.node_count() >= POOL;
		r.item_value  = $urandom();
		r.node_number = adll_pkg::NODE_W'(pick_node_k());
		roll          = $urandom_range(0, 99);
		if (roll < (full ? 15 : 42)) begin
			r.req_type = $urandom_range(0, 1) ? adll_pkg::REQ_INS_TAIL
				: adll_pkg::REQ_INS_HEAD;
		end else if (roll < (full ? 35 : 88)) begin
			r.req_type = $urandom_range(0, 1) ? adll_pkg::REQ_INS_RIGHT
				: adll_pkg::REQ_INS_LEFT;
		end else if (roll < (full ? 55 : 91)) begin
			r.req_type = adll_pkg::REQ_DELETE;
		end else if (roll < 98) begin
			r.req_type = adll_pkg::REQ_WALK;
			// start from the head, follow the last walk, or jump anywhere
			case ($urandom_range(0, 2))
				0:       r.node_number = '0;
				1:       r.node_number = adll_pkg::NODE_W'(walk_cursor);
				default: ;
			endcase
		end else begin
			r.req_type    = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
			r.node_number = adll_pkg::NODE_W'($urandom_range(0, (1 << adll_pkg::NODE_W) - 1));
		end
		return r;
	endfunction

	// Offer one request beat and hold it until accepted. Start is never dropped between
	// back-to-back beats; during idle cycles the request lines carry junk.
	task automatic send_req(adll_pkg::req_t r);
		adll_pkg::rsp_t e;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			req   <= make_req(adll_pkg::REQ_W'($urandom()), $urandom(), $urandom());
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		e = tracker.note_request(r);
		// follow the list: the next chained walk starts where this one landed
		if (r.req_type == adll_pkg::REQ_WALK && e.status == adll_pkg::STAT_OK)
			walk_cursor = e.at_end ? 0 : int'(e.result_node);
	endtask

	initial begin
		tracker         = new();
		sender_idle_pct = 11;
		walk_cursor     = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		req             = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, refusals, value extremes, deleted nodes, bad k.
		send_req(make_req(adll_pkg::REQ_WALK, 0, 0));       // walk of an empty list
		send_req(make_req(adll_pkg::REQ_DELETE, 0, 0));     // k of zero
		send_req(make_req(adll_pkg::REQ_DELETE, 1, 0));     // k beyond the node count
		send_req(make_req(adll_pkg::REQ_INS_LEFT, 1, 32'sd7));
		send_req(make_req(adll_pkg::REQ_INS_RIGHT, 0, 32'sd7));
		send_req(make_req(REQ_UNUSED_6, 2047, -1));         // unknown request codes
		send_req(make_req(REQ_UNUSED_7, 0, 0));
		send_req(make_req(adll_pkg::REQ_INS_HEAD, 0, 32'sh7FFF_FFFF));
		send_req(make_req(adll_pkg::REQ_INS_TAIL, 2047, 32'sh8000_0000));
		send_req(make_req(adll_pkg::REQ_INS_LEFT, 1, -1));
		send_req(make_req(adll_pkg::REQ_INS_RIGHT, 2, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 0, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 3, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 2, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 4, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 5, 0));       // one past the node count
		send_req(make_req(adll_pkg::REQ_WALK, 2047, 0));
		send_req(make_req(adll_pkg::REQ_DELETE, 1, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 1, 0));       // deleted node
		send_req(make_req(adll_pkg::REQ_INS_RIGHT, 1, 32'sd9));
		send_req(make_req(adll_pkg::REQ_DELETE, 1, 0));
		send_req(make_req(adll_pkg::REQ_WALK, 0, 0));
		send_req(make_req(adll_pkg::REQ_DELETE, 1024, 0));
		send_req(make_req(adll_pkg::REQ_INS_LEFT, 3, 32'sh5555_5555));
		send_req(make_req(adll_pkg::REQ_WALK, 3, 0));

		// Random: light sender gaps, then heavy ones, then back to back.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				sender_idle_pct = 71;
			else if (i == 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 0;
			send_req(make_random_req());
		end
		start <= 1'b0;

		// Drain: wait for every owed beat, then keep watching for strays.
		while (tracker.owed_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("tb_array_doubly_linked_list OK");
		else
			$display("tb_array_doubly_linked_list NOT OK");
		$finish;
	end

endmodule
